// File: src/mdh_pkg.sv
// Package for the manual drive handover controller.
// Holds shared types, codes and reset constants; depends on nothing.
package mdh_pkg;

  // Field widths fixed by the panel interface.
  localparam int unsigned SpeedW  = 10;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_MAX   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOME_SPEED  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SEND_PERIOD = 2'd3;

  // Configuration reset values.
  localparam logic [SpeedW-1:0]  STEP_SIZE_RST   = 10'd100;
  localparam logic [SpeedW-1:0]  SPEED_MAX_RST   = 10'd1000;
  localparam logic [SpeedW-1:0]  HOME_SPEED_RST  = 10'd300;
  localparam logic [PeriodW-1:0] SEND_PERIOD_RST = 16'd100;

  // Action codes on the result channel.
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_ESTOP   = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;
  localparam logic [1:0] ACT_SPEED   = 2'd3;

  // Movement codes, meaningful with a speed command.
  localparam logic [2:0] MOVE_NEUTRAL  = 3'd0;
  localparam logic [2:0] MOVE_FORWARD  = 3'd1;
  localparam logic [2:0] MOVE_BACKWARD = 3'd2;
  localparam logic [2:0] MOVE_LEFT     = 3'd3;
  localparam logic [2:0] MOVE_RIGHT    = 3'd4;

  // Mode codes as reported on the result channel.
  localparam logic [1:0] MODE_CODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_CODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_CODE_MANUAL = 2'd2;

  // Handover state machine, one-hot.
  typedef enum logic [2:0] {
    MODE_AUTO   = 3'b001,
    MODE_WAIT   = 3'b010,
    MODE_MANUAL = 3'b100
  } mode_t;

  // One panel sample.
  typedef struct packed {
    logic             estop;
    logic             selected_manual;
    logic             answer_received;
    logic             forward;
    logic             backward;
    logic             left;
    logic             right;
    logic             speed_up;
    logic             speed_down;
    logic [TimeW-1:0] now_ms;
  } item_t;

  // Configuration registers.
  typedef struct packed {
    logic [SpeedW-1:0]  step_size;
    logic [SpeedW-1:0]  speed_max;
    logic [SpeedW-1:0]  home_speed;
    logic [PeriodW-1:0] send_period_ms;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    step_size:      STEP_SIZE_RST,
    speed_max:      SPEED_MAX_RST,
    home_speed:     HOME_SPEED_RST,
    send_period_ms: SEND_PERIOD_RST
  };

  // Controller state carried from one item to the next.
  typedef struct packed {
    mode_t             mode;
    logic [SpeedW-1:0] preset_speed;
    logic              prev_up;
    logic              prev_down;
    logic [TimeW-1:0]  last_send_ms;
    logic              answer_latch;
    logic              panel_flag;
  } state_t;

  localparam state_t STATE_RST = '{
    mode:         MODE_AUTO,
    preset_speed: HOME_SPEED_RST,
    prev_up:      1'b0,
    prev_down:    1'b0,
    last_send_ms: '0,
    answer_latch: 1'b0,
    panel_flag:   1'b0
  };

  // One result item.
  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        movement;
    logic [SpeedW-1:0] speed;
    logic [1:0]        mode_state;
    logic              manual_mode;
    logic              panel_in_control;
    logic              estop_shown;
  } result_t;

  // Map the one-hot mode onto the reported code.
  function automatic logic [1:0] mode_code(input mode_t mode);
    logic [1:0] code;
    unique case (mode)
      MODE_WAIT:   code = MODE_CODE_WAIT;
      MODE_MANUAL: code = MODE_CODE_MANUAL;
      default:     code = MODE_CODE_AUTO;
    endcase
    return code;
  endfunction

endpackage

// File: src/mdh_step.sv
// Combinational step of the handover controller: one sample plus current state
// gives next state and one result item. Depends on mdh_pkg.
module mdh_step (
  input  mdh_pkg::item_t   item,
  input  mdh_pkg::cfg_t    cfg,
  input  mdh_pkg::state_t  st,
  output mdh_pkg::state_t  st_nxt,
  output mdh_pkg::result_t res
);

  logic                       up_edge;
  logic                       down_edge;
  logic [mdh_pkg::SpeedW:0]   up_sum;
  logic [mdh_pkg::SpeedW-1:0] up_val;
  logic [mdh_pkg::SpeedW-1:0] down_base;
  logic [mdh_pkg::SpeedW-1:0] down_val;
  logic [mdh_pkg::SpeedW-1:0] adj_speed;
  logic [mdh_pkg::TimeW-1:0]  elapsed;
  logic                       send_due;
  logic [2:0]                 direction;
  logic [1:0]                 action;
  logic [2:0]                 movement;

  // Button edges against the stored levels.
  assign up_edge   = item.speed_up & ~st.prev_up;
  assign down_edge = item.speed_down & ~st.prev_down;

  // Saturating up step, then saturating down step on its result.
  assign up_sum    = {1'b0, st.preset_speed} + {1'b0, cfg.step_size};
  assign up_val    = (up_sum <= {1'b0, cfg.speed_max}) ? up_sum[mdh_pkg::SpeedW-1:0]
                                                       : cfg.speed_max;
  assign down_base = up_edge ? up_val : st.preset_speed;
  assign down_val  = (down_base >= cfg.step_size) ? (down_base - cfg.step_size) : '0;
  assign adj_speed = down_edge ? down_val : down_base;

  // Wrapping time since the last speed command.
  assign elapsed  = item.now_ms - st.last_send_ms;
  assign send_due = elapsed >= {{(mdh_pkg::TimeW-mdh_pkg::PeriodW){1'b0}},
                                cfg.send_period_ms};

  // Direction priority: forward, backward, left, right.
  always_comb begin
    priority if (item.forward) begin
      direction = mdh_pkg::MOVE_FORWARD;
    end else if (item.backward) begin
      direction = mdh_pkg::MOVE_BACKWARD;
    end else if (item.left) begin
      direction = mdh_pkg::MOVE_LEFT;
    end else if (item.right) begin
      direction = mdh_pkg::MOVE_RIGHT;
    end else begin
      direction = mdh_pkg::MOVE_NEUTRAL;
    end
  end

  // Handover state machine. Estop wins and only the answer latch moves.
  always_comb begin
    st_nxt              = st;
    st_nxt.answer_latch = st.answer_latch | item.answer_received;
    action              = mdh_pkg::ACT_NONE;
    movement            = mdh_pkg::MOVE_NEUTRAL;
    if (item.estop) begin
      action = mdh_pkg::ACT_ESTOP;
    end else begin
      unique case (st.mode)
        mdh_pkg::MODE_WAIT: begin
          if (!item.selected_manual) begin
            st_nxt.answer_latch = 1'b0;
            st_nxt.mode         = mdh_pkg::MODE_AUTO;
          end else if (st_nxt.answer_latch) begin
            st_nxt.answer_latch = 1'b0;
            st_nxt.mode         = mdh_pkg::MODE_MANUAL;
            st_nxt.panel_flag   = 1'b1;
            st_nxt.preset_speed = cfg.home_speed;
            st_nxt.prev_up      = 1'b0;
            st_nxt.prev_down    = 1'b0;
            st_nxt.last_send_ms = '0;
          end
        end
        mdh_pkg::MODE_MANUAL: begin
          if (!item.selected_manual) begin
            st_nxt.preset_speed = cfg.home_speed;
            st_nxt.prev_up      = 1'b0;
            st_nxt.prev_down    = 1'b0;
            st_nxt.mode         = mdh_pkg::MODE_AUTO;
          end else begin
            st_nxt.prev_up      = item.speed_up;
            st_nxt.prev_down    = item.speed_down;
            st_nxt.preset_speed = adj_speed;
            if (send_due) begin
              st_nxt.last_send_ms = item.now_ms;
              action              = mdh_pkg::ACT_SPEED;
              movement            = direction;
            end
          end
        end
        default: begin
          // Auto, and any code that is not a legal mode.
          st_nxt.mode = mdh_pkg::MODE_AUTO;
          if (item.selected_manual) begin
            st_nxt.answer_latch = 1'b0;
            st_nxt.mode         = mdh_pkg::MODE_WAIT;
            action              = mdh_pkg::ACT_REQUEST;
          end
        end
      endcase
    end
  end

  // Result fields reflect the state after this sample.
  assign res.action           = action;
  assign res.movement         = movement;
  assign res.speed            = st_nxt.preset_speed;
  assign res.mode_state       = mdh_pkg::mode_code(st_nxt.mode);
  assign res.manual_mode      = (st_nxt.mode == mdh_pkg::MODE_MANUAL);
  assign res.panel_in_control = st_nxt.panel_flag;
  assign res.estop_shown      = item.estop;

endmodule

// File: src/manual_drive_handover_fsm.sv
// Top level of the manual drive handover controller: channels, registers and
// configuration. Depends on mdh_pkg and mdh_step.
//
// Takes one panel sample per clock while the output is not stalled and returns one
// result item per sample, in order. A sample is captured in an input register; the
// handover step runs once the result slot is free and writes the controller state
// and the result register at the same edge, so the sustained rate is one item per
// cycle while the output does not stall. While a result waits for the consumer,
// the input register can still take one more sample; after that the input stalls
// until the result is taken. Configuration writes are taken in every cycle
// (cfg_ready is always high); register indexes are 0 step size, 1 speed maximum,
// 2 home speed, 3 send period in milliseconds.
module manual_drive_handover_fsm (
  input  logic        clk,
  input  logic        rst_n,
  // Panel sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_estop,
  input  logic        in_selected_manual,
  input  logic        in_answer_received,
  input  logic        in_forward,
  input  logic        in_backward,
  input  logic        in_left,
  input  logic        in_right,
  input  logic        in_speed_up,
  input  logic        in_speed_down,
  input  logic [31:0] in_now_ms,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [2:0]  out_movement,
  output logic [9:0]  out_speed,
  output logic [1:0]  out_mode_state,
  output logic        out_manual_mode,
  output logic        out_panel_in_control,
  output logic        out_estop_shown,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mdh_pkg::item_t   item_r;
  logic             item_valid_r;
  mdh_pkg::cfg_t    cfg_r;
  mdh_pkg::cfg_t    cfg_nxt;
  mdh_pkg::state_t  state_r;
  mdh_pkg::state_t  state_nxt;
  mdh_pkg::result_t res_r;
  mdh_pkg::result_t step_res;
  logic             res_valid_r;
  logic             res_free;
  logic             step_fire;
  logic             in_take;

  // Handshake: the step fires when a sample is held and the result slot frees.
  assign res_free  = ~res_valid_r | ~out_stall;
  assign step_fire = item_valid_r & res_free;
  assign in_stall  = item_valid_r & ~res_free;
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (step_fire) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{
        estop:           in_estop,
        selected_manual: in_selected_manual,
        answer_received: in_answer_received,
        forward:         in_forward,
        backward:        in_backward,
        left:            in_left,
        right:           in_right,
        speed_up:        in_speed_up,
        speed_down:      in_speed_down,
        now_ms:          in_now_ms
      };
    end
  end

  // Configuration registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mdh_pkg::CFG_STEP_SIZE:   cfg_nxt.step_size      = cfg_data[mdh_pkg::SpeedW-1:0];
        mdh_pkg::CFG_SPEED_MAX:   cfg_nxt.speed_max      = cfg_data[mdh_pkg::SpeedW-1:0];
        mdh_pkg::CFG_HOME_SPEED:  cfg_nxt.home_speed     = cfg_data[mdh_pkg::SpeedW-1:0];
        mdh_pkg::CFG_SEND_PERIOD: cfg_nxt.send_period_ms = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mdh_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handover step logic.
  mdh_step u_step (
    .item   (item_r),
    .cfg    (cfg_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (step_res)
  );

  // Controller state advances with each fired step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdh_pkg::STATE_RST;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step_fire) begin
      res_valid_r <= 1'b1;
    end else if (~out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r <= step_res;
    end
  end

  assign out_valid            = res_valid_r;
  assign out_action           = res_r.action;
  assign out_movement         = res_r.movement;
  assign out_speed            = res_r.speed;
  assign out_mode_state       = res_r.mode_state;
  assign out_manual_mode      = res_r.manual_mode;
  assign out_panel_in_control = res_r.panel_in_control;
  assign out_estop_shown      = res_r.estop_shown;

  // The handover state stays one-hot.
  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.mode))
    else $error("handover mode lost its one-hot code");

  // Once the panel has taken control it keeps it until reset.
  a_panel_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.panel_flag |=> state_r.panel_flag)
    else $error("panel control flag dropped");

  // A speed command only comes out of manual mode.
  a_speed_in_manual: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == mdh_pkg::ACT_SPEED) |->
      (out_mode_state == mdh_pkg::MODE_CODE_MANUAL && out_manual_mode))
    else $error("speed command outside manual mode");

  // A direction is reported only with a speed command.
  a_move_with_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_movement != mdh_pkg::MOVE_NEUTRAL) |->
      (out_action == mdh_pkg::ACT_SPEED))
    else $error("movement reported without speed command");

  // An estop sample always yields the estop action.
  a_estop_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_estop_shown) |-> (out_action == mdh_pkg::ACT_ESTOP))
    else $error("estop sample without estop action");

endmodule

// File: dv/mdh_checker.sv
// Checker for the manual drive handover controller: predicts each result item
// from the accepted panel samples and register writes, and compares in order.
// Depends on mdh_pkg for the item, result and configuration types.
module mdh_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  mdh_pkg::item_t              in_sample,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  mdh_pkg::result_t            out_result,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [mdh_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mdh_pkg::CfgDatW-1:0] cfg_data,
  output int unsigned                 fail_count,
  output int unsigned                 awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers and of the handover state.
  mdh_pkg::cfg_t              settings;
  mdh_pkg::mode_t             handover_mode;
  logic [mdh_pkg::SpeedW-1:0] preset;
  logic                       up_level;
  logic                       down_level;
  logic [mdh_pkg::TimeW-1:0]  last_cmd_ms;
  logic                       answer_held;
  logic                       panel_taken;

  // Results predicted for accepted samples, oldest first.
  mdh_pkg::result_t panel_results_due[$];

  // Advance the shadow state by one panel sample and form its result.
  task automatic predict_handover(input mdh_pkg::item_t s, output mdh_pkg::result_t r);
    logic [1:0]                act;
    logic [2:0]                move;
    logic                      up_edge;
    logic                      down_edge;
    logic [mdh_pkg::TimeW-1:0] elapsed;
    int unsigned               raised;
    act  = mdh_pkg::ACT_NONE;
    move = mdh_pkg::MOVE_NEUTRAL;
    answer_held = answer_held | s.answer_received;
    if (s.estop) begin
      act = mdh_pkg::ACT_ESTOP;
    end else begin
      case (handover_mode)
        mdh_pkg::MODE_WAIT: begin
          if (!s.selected_manual) begin
            answer_held   = 1'b0;
            handover_mode = mdh_pkg::MODE_AUTO;
          end else if (answer_held) begin
            answer_held   = 1'b0;
            handover_mode = mdh_pkg::MODE_MANUAL;
            panel_taken   = 1'b1;
            preset        = settings.home_speed;
            up_level      = 1'b0;
            down_level    = 1'b0;
            last_cmd_ms   = '0;
          end
        end
        mdh_pkg::MODE_MANUAL: begin
          if (!s.selected_manual) begin
            preset        = settings.home_speed;
            up_level      = 1'b0;
            down_level    = 1'b0;
            handover_mode = mdh_pkg::MODE_AUTO;
          end else begin
            up_edge    = s.speed_up & ~up_level;
            down_edge  = s.speed_down & ~down_level;
            up_level   = s.speed_up;
            down_level = s.speed_down;
            // The up step saturates at the maximum, the down step at zero.
            if (up_edge) begin
              raised = 32'(preset) + 32'(settings.step_size);
              if (raised <= 32'(settings.speed_max)) preset = raised[mdh_pkg::SpeedW-1:0];
              else preset = settings.speed_max;
            end
            if (down_edge) begin
              if (preset >= settings.step_size) preset = preset - settings.step_size;
              else preset = '0;
            end
            // A speed command goes out once the wrapped elapsed time reaches the period.
            elapsed = s.now_ms - last_cmd_ms;
            if (elapsed >= {16'b0, settings.send_period_ms}) begin
              last_cmd_ms = s.now_ms;
              act = mdh_pkg::ACT_SPEED;
              if (s.forward) move = mdh_pkg::MOVE_FORWARD;
              else if (s.backward) move = mdh_pkg::MOVE_BACKWARD;
              else if (s.left) move = mdh_pkg::MOVE_LEFT;
              else if (s.right) move = mdh_pkg::MOVE_RIGHT;
            end
          end
        end
        default: begin
          handover_mode = mdh_pkg::MODE_AUTO;
          if (s.selected_manual) begin
            answer_held   = 1'b0;
            act           = mdh_pkg::ACT_REQUEST;
            handover_mode = mdh_pkg::MODE_WAIT;
          end
        end
      endcase
    end
    r.action      = act;
    r.movement    = move;
    r.speed       = preset;
    case (handover_mode)
      mdh_pkg::MODE_WAIT:   r.mode_state = mdh_pkg::MODE_CODE_WAIT;
      mdh_pkg::MODE_MANUAL: r.mode_state = mdh_pkg::MODE_CODE_MANUAL;
      default:              r.mode_state = mdh_pkg::MODE_CODE_AUTO;
    endcase
    r.manual_mode      = (handover_mode == mdh_pkg::MODE_MANUAL);
    r.panel_in_control = panel_taken;
    r.estop_shown      = s.estop;
  endtask

  task automatic match_field(input string label, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
      fail_count++;
    end
  endtask

  // Sample all three channels at each rising edge.
  always @(posedge clk) begin : watch
    mdh_pkg::result_t want;
    mdh_pkg::result_t next_due;
    if (!rst_n) begin
      settings      = mdh_pkg::CFG_RST;
      handover_mode = mdh_pkg::MODE_AUTO;
      preset        = mdh_pkg::HOME_SPEED_RST;
      up_level      = 1'b0;
      down_level    = 1'b0;
      last_cmd_ms   = '0;
      answer_held   = 1'b0;
      panel_taken   = 1'b0;
      fail_count    = 0;
      panel_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mdh_pkg::CFG_STEP_SIZE:   settings.step_size      = cfg_data[mdh_pkg::SpeedW-1:0];
          mdh_pkg::CFG_SPEED_MAX:   settings.speed_max      = cfg_data[mdh_pkg::SpeedW-1:0];
          mdh_pkg::CFG_HOME_SPEED:  settings.home_speed     = cfg_data[mdh_pkg::SpeedW-1:0];
          mdh_pkg::CFG_SEND_PERIOD: settings.send_period_ms = cfg_data[mdh_pkg::PeriodW-1:0];
          default: ;
        endcase
      end
      // Retire the oldest expectation before queuing the one for this edge.
      if (out_valid && !out_stall) begin
        if (panel_results_due.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, out_result);
          fail_count++;
        end else begin
          want = panel_results_due.pop_front();
          match_field("action", want.action, out_result.action);
          match_field("movement", want.movement, out_result.movement);
          match_field("speed", want.speed, out_result.speed);
          match_field("mode_state", want.mode_state, out_result.mode_state);
          match_field("manual_mode", want.manual_mode, out_result.manual_mode);
          match_field("panel_in_control", want.panel_in_control,
                      out_result.panel_in_control);
          match_field("estop_shown", want.estop_shown, out_result.estop_shown);
        end
      end
      if (in_valid && !in_stall) begin
        predict_handover(in_sample, next_due);
        panel_results_due.push_back(next_due);
      end
    end
    awaited = panel_results_due.size();
  end

endmodule

// File: dv/tb.sv
// Testbench top for the manual drive handover controller: clock, reset,
// panel samples, register writes, result back-pressure and the verdict.
// Depends on mdh_pkg, manual_drive_handover_fsm and mdh_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  // Direction button sets, ordered forward, backward, left, right.
  localparam logic [3:0] BTN_NONE  = 4'b0000;
  localparam logic [3:0] BTN_FWD   = 4'b1000;
  localparam logic [3:0] BTN_BACK  = 4'b0100;
  localparam logic [3:0] BTN_LEFT  = 4'b0010;
  localparam logic [3:0] BTN_RIGHT = 4'b0001;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  mdh_pkg::item_t              sample;
  logic                        out_valid;
  logic                        out_stall;
  logic [1:0]                  out_action;
  logic [2:0]                  out_movement;
  logic [9:0]                  out_speed;
  logic [1:0]                  out_mode_state;
  logic                        out_manual_mode;
  logic                        out_panel_in_control;
  logic                        out_estop_shown;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [mdh_pkg::CfgIdxW-1:0] cfg_index;
  logic [mdh_pkg::CfgDatW-1:0] cfg_data;
  mdh_pkg::result_t            seen;
  int unsigned                 fail_count;
  int unsigned                 awaited;

  // Stimulus shaping state.
  logic                        in_quiet;
  logic                        out_quiet;
  logic [mdh_pkg::TimeW-1:0]   clock_ms;
  int unsigned                 period_now;
  int unsigned                 items_sent;
  int unsigned                 cycles = 0;

  assign seen = {out_action, out_movement, out_speed, out_mode_state,
                 out_manual_mode, out_panel_in_control, out_estop_shown};

  manual_drive_handover_fsm u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_estop            (sample.estop),
    .in_selected_manual  (sample.selected_manual),
    .in_answer_received  (sample.answer_received),
    .in_forward          (sample.forward),
    .in_backward         (sample.backward),
    .in_left             (sample.left),
    .in_right            (sample.right),
    .in_speed_up         (sample.speed_up),
    .in_speed_down       (sample.speed_down),
    .in_now_ms           (sample.now_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_movement        (out_movement),
    .out_speed           (out_speed),
    .out_mode_state      (out_mode_state),
    .out_manual_mode     (out_manual_mode),
    .out_panel_in_control(out_panel_in_control),
    .out_estop_shown     (out_estop_shown),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  mdh_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(seen),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .awaited   (awaited)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result back-pressure: a fresh random stall, possibly none, ahead of every result item unless out_quiet is set.
  initial begin : result_stall
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic mdh_pkg::item_t panel(input logic stop, input logic sel,
                                           input logic ans, input logic [3:0] dirs,
                                           input logic up, input logic dn,
                                           input logic [mdh_pkg::TimeW-1:0] ms);
    mdh_pkg::item_t s;
    s.estop           = stop;
    s.selected_manual = sel;
    s.answer_received = ans;
    s.forward         = dirs[3];
    s.backward        = dirs[2];
    s.left            = dirs[1];
    s.right           = dirs[0];
    s.speed_up        = up;
    s.speed_down      = dn;
    s.now_ms          = ms;
    return s;
  endfunction

  // Time between samples, mostly around the send period, now and then a jump.
  function automatic logic [mdh_pkg::TimeW-1:0] step_ms();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return $urandom_range(0, 2 * period_now + 2);
  endfunction

  // Present one sample after a random gap and hold it until it is taken.
  task automatic send_panel(input mdh_pkg::item_t s);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample   <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [mdh_pkg::CfgIdxW-1:0] idx,
                           input logic [mdh_pkg::CfgDatW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers; unused upper data bits carry junk.
  task automatic load_config(input logic [mdh_pkg::SpeedW-1:0] step,
                             input logic [mdh_pkg::SpeedW-1:0] top,
                             input logic [mdh_pkg::SpeedW-1:0] dflt,
                             input logic [mdh_pkg::PeriodW-1:0] period);
    write_reg(mdh_pkg::CFG_STEP_SIZE, {6'($urandom), step});
    write_reg(mdh_pkg::CFG_SPEED_MAX, {6'($urandom), top});
    write_reg(mdh_pkg::CFG_HOME_SPEED, {6'($urandom), dflt});
    write_reg(mdh_pkg::CFG_SEND_PERIOD, period);
    cfg_valid  <= 1'b0;
    period_now = 32'(period);
  endtask

  // Request, wait for the answer, drive a while in manual, then hand back.
  task automatic run_session();
    int unsigned waits;
    int unsigned drive_len;
    send_panel(panel(1'b0, 1'b1, 1'($urandom), 4'($urandom), 1'($urandom),
                     1'($urandom), clock_ms));
    waits = $urandom_range(0, 3);
    repeat (waits) begin
      clock_ms += 32'($urandom_range(0, 50));
      send_panel(panel(1'($urandom_range(0, 9) == 0), 1'b1, 1'b0, 4'($urandom),
                       1'($urandom), 1'($urandom), clock_ms));
    end
    // Now and then the switch drops back before the answer comes.
    if ($urandom_range(0, 9) == 0) begin
      send_panel(panel(1'b0, 1'b0, 1'($urandom), 4'($urandom), 1'($urandom),
                       1'($urandom), clock_ms));
      return;
    end
    send_panel(panel(1'b0, 1'b1, 1'b1, 4'($urandom), 1'($urandom), 1'($urandom),
                     clock_ms));
    drive_len = $urandom_range(3, 20);
    repeat (drive_len) begin
      clock_ms += step_ms();
      send_panel(panel(1'($urandom_range(0, 29) == 0), 1'b1, 1'($urandom),
                       4'($urandom), 1'($urandom), 1'($urandom), clock_ms));
    end
    send_panel(panel(1'b0, 1'b0, 1'b0, 4'($urandom), 1'($urandom), 1'($urandom),
                     clock_ms));
  endtask

  // Mostly handover sessions, the rest fully random samples.
  task automatic run_phase(input int unsigned quota);
    int unsigned target;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 75) begin
        run_session();
      end else begin
        send_panel(panel(1'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
                         1'($urandom), 1'($urandom), $urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    sample     <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= mdh_pkg::CFG_STEP_SIZE;
    cfg_data   <= '0;
    items_sent = 0;
    in_quiet   = 1'b0;
    out_quiet  = 1'b0;
    period_now = 32'(mdh_pkg::SEND_PERIOD_RST);
    clock_ms   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk through the handover with the reset settings.
    // Estop in auto wins over a manual request.
    send_panel(panel(1'b1, 1'b1, 1'b0, BTN_NONE, 1'b0, 1'b0, 32'd0));
    // An answer seen in auto is latched, then dropped by the request.
    send_panel(panel(1'b0, 1'b0, 1'b1, BTN_NONE, 1'b0, 1'b0, 32'd5));
    send_panel(panel(1'b0, 1'b1, 1'b1, BTN_NONE, 1'b0, 1'b0, 32'd10));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_NONE, 1'b0, 1'b0, 32'd15));
    // The answer is still captured while estop holds the machine.
    send_panel(panel(1'b1, 1'b1, 1'b1, 4'b1111, 1'b1, 1'b1, 32'd20));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_NONE, 1'b1, 1'b0, 32'd0));
    // Speed steps and the direction priority in manual.
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_NONE, 1'b1, 1'b0, 32'd50));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_FWD | BTN_BACK, 1'b1, 1'b1, 32'd100));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_BACK | BTN_LEFT | BTN_RIGHT, 1'b0, 1'b0,
                     32'd200));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_LEFT | BTN_RIGHT, 1'b0, 1'b0, 32'd300));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_RIGHT, 1'b0, 1'b0, 32'd400));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_NONE, 1'b0, 1'b0, 32'd500));
    // Both speed edges in one sample.
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_FWD, 1'b1, 1'b1, 32'd550));
    // Timestamp wrap around the top of the counter.
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_FWD, 1'b0, 1'b0, 32'hFFFF_FFC0));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_FWD, 1'b0, 1'b0, 32'h0000_0010));
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_BACK, 1'b0, 1'b0, 32'h0000_0024));
    // Estop in manual, then leaving manual.
    send_panel(panel(1'b1, 1'b0, 1'b0, BTN_FWD, 1'b1, 1'b0, 32'h0000_0100));
    send_panel(panel(1'b0, 1'b0, 1'b0, BTN_NONE, 1'b0, 1'b0, 32'h0000_0200));
    // A request abandoned while waiting.
    send_panel(panel(1'b0, 1'b1, 1'b0, BTN_NONE, 1'b0, 1'b0, 32'h0000_0300));
    send_panel(panel(1'b0, 1'b0, 1'b1, BTN_NONE, 1'b0, 1'b0, 32'h0000_0400));
    send_panel(panel(1'b0, 1'b0, 1'b0, 4'b1111, 1'b1, 1'b1, 32'hFFFF_FFFF));

    // Random phases, each under its own register setting and idling mix.
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: load_config(mdh_pkg::STEP_SIZE_RST, mdh_pkg::SPEED_MAX_RST,
                       mdh_pkg::HOME_SPEED_RST, mdh_pkg::SEND_PERIOD_RST);
        1: load_config(10'd1023, 10'd1023, 10'd1023, 16'd0);
        2: load_config(10'd0, 10'd0, 10'd0, 16'hFFFF);
        3: load_config(10'd1, 10'd1000, 10'd1023, 16'd1);
        4: load_config(10'($urandom_range(0, 300)), 10'($urandom), 10'($urandom),
                       16'($urandom_range(0, 200)));
        default: load_config(10'($urandom), 10'($urandom), 10'($urandom), 16'($urandom));
      endcase
      in_quiet  = (p == 1 || p == 3);
      out_quiet = (p == 2 || p == 3);
      clock_ms  = $urandom;
      run_phase(80);
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
